// ----- hdl/sgv_pkg.sv -----
package sgv_pkg;

  localparam int MAX_COLUMNS_DEF  = 256;
  localparam int ANGLE_STAGES_DEF = 16;
  localparam int DIV_STEPS        = 32;
  localparam int QW               = DIV_STEPS + 1;
  localparam int CXW              = 32;
  localparam int CZW              = 33;
  localparam int TEX_LSB          = 17;

  localparam logic [CXW-1:0] CORDIC_GAIN = 32'h26DD3B6A;
  localparam logic [8:0]     COLUMNS_RST = 9'd32;
  localparam logic [15:0]    RADIUS_RST  = 16'h8000;

  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_RADIUS  = 1'b1;

  typedef struct packed {
    logic [7:0] row_index;
    logic [7:0] col_index;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [15:0]        vertex_index;
    logic               in_range;
  } out_beat_t;

  typedef struct packed {
    logic        in_range;
    logic [15:0] vidx;
  } side_t;

  typedef struct packed {
    logic        in_range;
    logic [15:0] vidx;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic        flip_t;
    logic        flip_p;
  } late_t;

  typedef struct packed {
    logic signed [CZW-1:0] z;
    logic                  flip;
  } fold_t;

  function automatic logic [31:0] atan_turn(input int k);
    logic [31:0] a;
    unique case (k)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

  // bring an angle into [-90, 90] degrees, flag a half-turn
  function automatic fold_t fold_angle(input logic [31:0] ang);
    fold_t f;
    logic signed [CZW-1:0] za;
    za = $signed({ang[31], ang});
    f.flip = 1'b0;
    f.z = za;
    if (za > 33'sd1073741824) begin
      f.z = za - 33'sd2147483648;
      f.flip = 1'b1;
    end else if (za < -33'sd1073741824) begin
      f.z = za + 33'sd2147483648;
      f.flip = 1'b1;
    end
    return f;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] s;
    if (v > 64'sd32767) begin
      s = 16'sh7FFF;
    end else if (v < -64'sd32768) begin
      s = -16'sh8000;
    end else begin
      s = v[15:0];
    end
    return s;
  endfunction

endpackage

// ----- hdl/sgv_in_if.sv -----
interface sgv_in_if import sgv_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/sgv_out_if.sv -----
interface sgv_out_if import sgv_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/sgv_div_cell.sv -----
module sgv_div_cell import sgv_pkg::*; #(
  parameter int CW = 9
) (
  input  logic          clk,
  input  logic          en,
  input  logic [CW-1:0] d_i,
  input  logic [CW-1:0] r_i,
  input  logic [QW-1:0] q_i,
  input  logic [31:0]   x_i,
  output logic [CW-1:0] d_o,
  output logic [CW-1:0] r_o,
  output logic [QW-1:0] q_o,
  output logic [31:0]   x_o
);

  logic [CW:0]   s;
  logic [CW:0]   d_ext;
  logic          ge;
  logic [CW-1:0] d_r, r_r;
  logic [QW-1:0] q_r;
  logic [31:0]   x_r;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign s     = {r_i, x_i[31]};
  assign d_ext = {1'b0, d_i};
  assign ge    = (s >= d_ext);

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_i;
      r_r <= ge ? CW'(s - d_ext) : CW'(s);
      q_r <= {q_i[QW-2:0], ge};
      x_r <= {x_i[30:0], 1'b0};
    end
  end

  assign d_o = d_r;
  assign r_o = r_r;
  assign q_o = q_r;
  assign x_o = x_r;

endmodule

// ----- hdl/sgv_cordic_cell.sv -----
module sgv_cordic_cell import sgv_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [CXW-1:0] x_i,
  input  logic signed [CXW-1:0] y_i,
  input  logic signed [CZW-1:0] z_i,
  output logic signed [CXW-1:0] x_o,
  output logic signed [CXW-1:0] y_o,
  output logic signed [CZW-1:0] z_o
);

  logic signed [CXW-1:0] dx, dy;
  logic signed [CZW-1:0] at;
  logic signed [CXW-1:0] x_r, y_r;
  logic signed [CZW-1:0] z_r;

  assign dx = x_i >>> STAGE;
  assign dy = y_i >>> STAGE;
  assign at = $signed(CZW'(atan_turn(STAGE)));

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_i >= 0) begin
        x_r <= x_i - dy;
        y_r <= y_i + dx;
        z_r <= z_i - at;
      end else begin
        x_r <= x_i + dy;
        y_r <= y_i - dx;
        z_r <= z_i + at;
      end
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

// ----- hdl/sphere_grid_vertex_generator_core.sv -----
// UV-sphere vertex generator.
// in_ch carries one grid point per beat (row_index, col_index); out_ch returns
// one vertex per beat: position, unit normal, texture coordinates, flat index
// and in_range. Results leave in the order the points came in.
// cfg_we/cfg_index/cfg_wdata write columns (index 0) and radius (index 1);
// write them only while no point is in flight.
// Throughput: one point per cycle while out_ch does not stall. From the
// accepting edge to out_ch.valid a point passes one setup stage,
// 32 restoring-division cells that produce both angles and both texture
// coordinates, one angle fold stage, ANGLE_STAGES rotation cells, two
// multiply stages, a rounding stage and the output register.
// Reset sets columns to 32 and radius to 1.0 and empties the pipeline.
// When out_ch stalls, the result holds in the output register; the pipeline
// keeps moving and in_ch stays ready as long as its last stage is empty,
// then the whole pipeline freezes and in_ch.ready drops.
module sphere_grid_vertex_generator_core import sgv_pkg::*; #(
  parameter int MAX_COLUMNS  = MAX_COLUMNS_DEF,
  parameter int ANGLE_STAGES = ANGLE_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  sgv_in_if.sink      in_ch,
  sgv_out_if.source   out_ch
);

  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int NL = 4;
  localparam int L_POL = 0;
  localparam int L_AZ  = 1;
  localparam int L_U   = 2;
  localparam int L_V   = 3;

  logic [8:0]  columns_r;
  logic [15:0] radius_r;
  logic        en;
  logic        en_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLUMNS_RST;
      radius_r  <= RADIUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLUMNS: columns_r <= cfg_wdata[8:0];
        REG_RADIUS:  radius_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // setup
  logic [15:0]   col16, i16, j16, vidx_c;
  logic [CW-1:0] cols_c, rd_c, cd_c;
  logic          rng_c;
  logic [CW-1:0] a_c [NL];
  logic [CW-1:0] d_c [NL];
  logic [CW-1:0] h_c [NL];

  always_comb begin
    col16 = 16'(columns_r);
    if (col16 < 16'd3) begin
      cols_c = CW'(3);
    end else if (col16 > 16'(MAX_COLUMNS)) begin
      cols_c = CW'(MAX_COLUMNS);
    end else begin
      cols_c = CW'(col16);
    end
    rd_c   = cols_c >> 1;
    cd_c   = cols_c - CW'(1);
    i16    = 16'(in_ch.data.row_index);
    j16    = 16'(in_ch.data.col_index);
    rng_c  = (i16 <= 16'(rd_c)) && (j16 <= 16'(cd_c));
    vidx_c = i16 * 16'(cols_c) + j16;
    a_c[L_POL] = CW'(i16);
    a_c[L_AZ]  = CW'(j16);
    a_c[L_U]   = cd_c - CW'(j16);
    a_c[L_V]   = rd_c - CW'(i16);
    d_c[L_POL] = rd_c;
    d_c[L_AZ]  = cd_c;
    d_c[L_U]   = cd_c;
    d_c[L_V]   = rd_c;
    h_c[L_POL] = '0;
    h_c[L_AZ]  = '0;
    h_c[L_U]   = cd_c >> 1;
    h_c[L_V]   = rd_c >> 1;
  end

  logic [CW-1:0] ch_d [0:DIV_STEPS][NL];
  logic [CW-1:0] ch_r [0:DIV_STEPS][NL];
  logic [QW-1:0] ch_q [0:DIV_STEPS][NL];
  logic [31:0]   ch_x [0:DIV_STEPS][NL];
  logic [CW-1:0] f_d_r [NL];
  logic [CW-1:0] f_r_r [NL];
  logic [QW-1:0] f_q_r [NL];
  logic [31:0]   f_x_r [NL];
  logic          dv_r [0:DIV_STEPS];
  side_t         ds_r [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NL; l++) begin
        f_d_r[l] <= d_c[l];
        f_r_r[l] <= (a_c[l] >= d_c[l]) ? a_c[l] - d_c[l] : a_c[l];
        f_q_r[l] <= QW'(a_c[l] >= d_c[l]);
        f_x_r[l] <= 32'(h_c[l]) << TEX_LSB;
      end
      ds_r[0] <= '{in_range: rng_c, vidx: vidx_c};
      for (int k = 0; k < DIV_STEPS; k++) begin
        ds_r[k+1] <= ds_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
        dv_r[k] <= 1'b0;
      end
    end else if (en) begin
      dv_r[0] <= in_ch.valid;
      for (int k = 0; k < DIV_STEPS; k++) begin
        dv_r[k+1] <= dv_r[k];
      end
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    assign ch_d[0][l] = f_d_r[l];
    assign ch_r[0][l] = f_r_r[l];
    assign ch_q[0][l] = f_q_r[l];
    assign ch_x[0][l] = f_x_r[l];
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      sgv_div_cell #(.CW(CW)) u_cell (
        .clk (clk),
        .en  (en),
        .d_i (ch_d[k][l]),
        .r_i (ch_r[k][l]),
        .q_i (ch_q[k][l]),
        .x_i (ch_x[k][l]),
        .d_o (ch_d[k+1][l]),
        .r_o (ch_r[k+1][l]),
        .q_o (ch_q[k+1][l]),
        .x_o (ch_x[k+1][l])
      );
    end
  end

  // angle fold and rotation chain
  fold_t                 fold_t_c, fold_p_c;
  logic signed [CZW-1:0] pz_r [2];
  logic signed [CXW-1:0] cx [0:ANGLE_STAGES][2];
  logic signed [CXW-1:0] cy [0:ANGLE_STAGES][2];
  logic signed [CZW-1:0] cz [0:ANGLE_STAGES][2];
  late_t                 lt_r [0:ANGLE_STAGES];
  logic                  cv_r [0:ANGLE_STAGES];

  assign fold_t_c = fold_angle(ch_q[DIV_STEPS][L_POL][QW-1:1]);
  assign fold_p_c = fold_angle(ch_q[DIV_STEPS][L_AZ][31:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      pz_r[0] <= fold_t_c.z;
      pz_r[1] <= fold_p_c.z;
      lt_r[0] <= '{in_range: ds_r[DIV_STEPS].in_range,
                   vidx:     ds_r[DIV_STEPS].vidx,
                   tex_u:    ch_q[DIV_STEPS][L_U][QW-1:TEX_LSB],
                   tex_v:    ch_q[DIV_STEPS][L_V][QW-1:TEX_LSB],
                   flip_t:   fold_t_c.flip,
                   flip_p:   fold_p_c.flip};
      for (int k = 0; k < ANGLE_STAGES; k++) begin
        lt_r[k+1] <= lt_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= ANGLE_STAGES; k++) begin
        cv_r[k] <= 1'b0;
      end
    end else if (en) begin
      cv_r[0] <= dv_r[DIV_STEPS];
      for (int k = 0; k < ANGLE_STAGES; k++) begin
        cv_r[k+1] <= cv_r[k];
      end
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_rot
    assign cx[0][a] = $signed(CORDIC_GAIN);
    assign cy[0][a] = '0;
    assign cz[0][a] = pz_r[a];
    for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_cell
      sgv_cordic_cell #(.STAGE(k)) u_cell (
        .clk (clk),
        .en  (en),
        .x_i (cx[k][a]),
        .y_i (cy[k][a]),
        .z_i (cz[k][a]),
        .x_o (cx[k+1][a]),
        .y_o (cy[k+1][a]),
        .z_o (cz[k+1][a])
      );
    end
  end

  // direction products
  logic signed [CXW-1:0] ct_c, st_c, cp_c, sp_c;
  logic signed [63:0]    p0_r, p2_r, t0_c, t2_c;
  logic signed [CXW-1:0] m1_u1_r;
  late_t                 m1_lt_r, m2_lt_r, m3_lt_r;
  logic                  m1_v_r, m2_v_r, m3_v_r;
  logic signed [CXW-1:0] u_r [3];
  logic signed [CXW-1:0] m3_u_r [3];
  logic signed [48:0]    pr_r [3];
  logic signed [16:0]    rad_s;

  assign ct_c = lt_r[ANGLE_STAGES].flip_t ? -cx[ANGLE_STAGES][0] : cx[ANGLE_STAGES][0];
  assign st_c = lt_r[ANGLE_STAGES].flip_t ? -cy[ANGLE_STAGES][0] : cy[ANGLE_STAGES][0];
  assign cp_c = lt_r[ANGLE_STAGES].flip_p ? -cx[ANGLE_STAGES][1] : cx[ANGLE_STAGES][1];
  assign sp_c = lt_r[ANGLE_STAGES].flip_p ? -cy[ANGLE_STAGES][1] : cy[ANGLE_STAGES][1];
  assign t0_c = p0_r + 64'sd536870912;
  assign t2_c = p2_r + 64'sd536870912;
  assign rad_s = $signed({1'b0, radius_r});

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r    <= st_c * cp_c;
      p2_r    <= st_c * sp_c;
      m1_u1_r <= ct_c;
      m1_lt_r <= lt_r[ANGLE_STAGES];
      u_r[0]  <= t0_c[61:30];
      u_r[1]  <= m1_u1_r;
      u_r[2]  <= -t2_c[61:30];
      m2_lt_r <= m1_lt_r;
      for (int n = 0; n < 3; n++) begin
        pr_r[n]   <= u_r[n] * rad_s;
        m3_u_r[n] <= u_r[n];
      end
      m3_lt_r <= m2_lt_r;
    end
  end

  // rounding, saturation and output register
  logic signed [15:0] pos_c [3];
  logic signed [15:0] nrm_c [3];
  logic               out_v_r;
  out_beat_t          out_r;

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      pos_c[n] = sat16((64'(pr_r[n]) + 64'sd536870912) >>> 30);
      nrm_c[n] = sat16((64'(m3_u_r[n]) + 64'sd16384) >>> 15);
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      if (m3_lt_r.in_range) begin
        out_r <= '{pos_x: pos_c[0], pos_y: pos_c[1], pos_z: pos_c[2],
                   norm_x: nrm_c[0], norm_y: nrm_c[1], norm_z: nrm_c[2],
                   tex_u: m3_lt_r.tex_u, tex_v: m3_lt_r.tex_v,
                   vertex_index: m3_lt_r.vidx, in_range: 1'b1};
      end else begin
        out_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r  <= 1'b0;
      m2_v_r  <= 1'b0;
      m3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en) begin
        m1_v_r <= cv_r[ANGLE_STAGES];
        m2_v_r <= m1_v_r;
        m3_v_r <= m2_v_r;
      end
      if (en_out) begin
        out_v_r <= m3_v_r;
      end
    end
  end

  // freeze only when a waiting result would be overwritten by a real one
  assign en_out       = out_ch.ready || !out_v_r;
  assign en           = en_out || !m3_v_r;
  assign in_ch.ready  = en;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.data.in_range |->
      out_ch.data.vertex_index == 16'd0 && out_ch.data.tex_u == 16'd0 &&
      out_ch.data.pos_x == 16'sd0 && out_ch.data.norm_y == 16'sd0)
    else $error("out-of-grid vertex carries nonzero fields");

  a_tex_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.in_range |->
      out_ch.data.tex_u <= 16'd32768 && out_ch.data.tex_v <= 16'd32768)
    else $error("texture coordinate above 1.0");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r && $stable(out_r))
    else $error("waiting result lost");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_v_r && m3_v_r && !out_ch.ready)
    else $error("input stalled without a blocked result");

endmodule
